### rtl/ost_pkg.sv
// shared constants and types for the owned slot table
`default_nettype none

package ost_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);
    localparam logic [7:0]       SLOT_CNT  = 8'(NUM_SLOTS);
    localparam logic [7:0]       NO_SLOT   = 8'd255;
    localparam logic [7:0]       TYPE_FREE = 8'd0;

    typedef enum logic [2:0] {
        OP_WRITE_HDR  = 3'd0,
        OP_FREE       = 3'd1,
        OP_FIND       = 3'd2,
        OP_COUNT_TYPE = 3'd3,
        OP_COUNT_OWN  = 3'd4,
        OP_FIRST_FREE = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_type_en;
        logic             wr_owner_en;
        logic [IDX_W-1:0] wr_addr;
        logic [7:0]       wr_type;
        logic [7:0]       wr_owner;
    } t_mem_req;

endpackage

`default_nettype wire

### rtl/ost_slot_mem.sv
// slot type and owner memories with per-entry valid bits for reset values
`default_nettype none

module ost_slot_mem (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ost_pkg::t_mem_req i_req,
    output logic [7:0]            o_rd_type,
    output logic [7:0]            o_rd_owner
);

    logic [7:0] type_mem  [ost_pkg::NUM_SLOTS];
    logic [7:0] owner_mem [ost_pkg::NUM_SLOTS];

    logic [ost_pkg::NUM_SLOTS-1:0] r_valid;
    logic [ost_pkg::NUM_SLOTS-1:0] n_valid;

    logic [7:0] r_type_q;
    logic [7:0] r_owner_q;
    logic       r_valid_q;

    // an entry becomes valid only with a full header write
    always_comb begin
        n_valid = r_valid;
        if (i_req.wr_owner_en) begin
            n_valid[i_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_type_en) begin
            type_mem[i_req.wr_addr] <= i_req.wr_type;
        end
        if (i_req.wr_owner_en) begin
            owner_mem[i_req.wr_addr] <= i_req.wr_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type_q  <= type_mem[i_req.rd_addr];
        r_owner_q <= owner_mem[i_req.rd_addr];
        r_valid_q <= r_valid[i_req.rd_addr];
    end

    assign o_rd_type  = r_valid_q ? r_type_q  : ost_pkg::TYPE_FREE;
    assign o_rd_owner = r_valid_q ? r_owner_q : ost_pkg::NO_SLOT;

endmodule

`default_nettype wire

### rtl/owned_slot_table.sv
// owned slot table: command sequencer sweeping the slot memories
// write header, out-of-range free and find, and unused opcodes answer in the next cycle; find,
//   count and first free sweep the slots (one memory read per slot, one read port)
// free: repeats full sweeps of the slots until one sweep frees nothing
// one transaction at a time; result strobe lasts one cycle, the receiver cannot stall
// reset clears the valid bits at once: every slot reads free with no owner, no clearing pass
`default_nettype none

module owned_slot_table (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_opcode,
    input  wire logic [7:0] i_slot_index,
    input  wire logic [7:0] i_item_type,
    input  wire logic [7:0] i_owner_id,
    output logic            o_result_strobe,
    output logic [7:0]      o_result_value
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SWEEP = 2'b10
    } t_state;

    localparam int IW = ost_pkg::IDX_W;
    localparam int NS = ost_pkg::NUM_SLOTS;

    t_state r_state, n_state;
    ost_pkg::t_opcode r_op, n_op;
    logic [7:0]    r_typ, n_typ;
    logic [7:0]    r_own, n_own;
    logic [IW-1:0] r_addr, n_addr;
    logic          r_issue, n_issue;
    logic          r_ev_v, n_ev_v;
    logic [IW-1:0] r_ev_addr, n_ev_addr;
    logic          r_ev_last, n_ev_last;
    logic [NS-1:0] r_marked, n_marked;
    logic          r_changed, n_changed;
    logic [7:0]    r_count, n_count;
    logic          r_strobe, n_strobe;
    logic [7:0]    r_result, n_result;

    ost_pkg::t_mem_req mem_req;
    logic [7:0] rd_type;
    logic [7:0] rd_owner;

    logic in_range;
    logic owner_in_range;
    logic cascade_hit;
    logic match;

    ost_slot_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd_type  (rd_type),
        .o_rd_owner (rd_owner)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result_value  = r_result;

    assign in_range       = (i_slot_index < ost_pkg::SLOT_CNT);
    assign owner_in_range = (rd_owner < ost_pkg::SLOT_CNT);

    // occupied slot owned by a freed slot and not freed yet
    assign cascade_hit = (rd_type != ost_pkg::TYPE_FREE) && owner_in_range
                         && r_marked[rd_owner[IW-1:0]] && !r_marked[r_ev_addr];

    always_comb begin
        match = 1'b0;
        unique case (r_op)
            ost_pkg::OP_FIND: begin
                match = (rd_type == r_typ)
                        && ((r_own == ost_pkg::NO_SLOT) || (rd_owner == r_own));
            end
            ost_pkg::OP_COUNT_TYPE: begin
                match = (rd_type == r_typ);
            end
            ost_pkg::OP_COUNT_OWN: begin
                match = (rd_type != ost_pkg::TYPE_FREE) && (rd_owner == r_own);
            end
            ost_pkg::OP_FIRST_FREE: begin
                match = (rd_type == ost_pkg::TYPE_FREE);
            end
            default: begin
                match = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_typ     = r_typ;
        n_own     = r_own;
        n_addr    = r_addr;
        n_issue   = r_issue;
        n_ev_v    = 1'b0;
        n_ev_addr = r_ev_addr;
        n_ev_last = r_ev_last;
        n_marked  = r_marked;
        n_changed = r_changed;
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_result  = r_result;

        mem_req             = '0;
        mem_req.rd_addr     = r_addr;
        mem_req.wr_addr     = i_slot_index[IW-1:0];
        mem_req.wr_type     = i_item_type;
        mem_req.wr_owner    = i_owner_id;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = ost_pkg::t_opcode'(i_opcode);
                    n_typ     = i_item_type;
                    n_own     = i_owner_id;
                    n_addr    = '0;
                    n_issue   = 1'b1;
                    n_changed = 1'b0;
                    n_count   = '0;
                    unique case (ost_pkg::t_opcode'(i_opcode))
                        ost_pkg::OP_WRITE_HDR: begin
                            mem_req.wr_type_en  = in_range;
                            mem_req.wr_owner_en = in_range;
                            n_strobe = 1'b1;
                            n_result = '0;
                            n_issue  = 1'b0;
                        end
                        ost_pkg::OP_FREE: begin
                            if (in_range) begin
                                mem_req.wr_type_en = 1'b1;
                                mem_req.wr_type    = ost_pkg::TYPE_FREE;
                                n_marked = '0;
                                n_marked[i_slot_index[IW-1:0]] = 1'b1;
                                n_state  = S_SWEEP;
                            end else begin
                                n_strobe = 1'b1;
                                n_result = '0;
                                n_issue  = 1'b0;
                            end
                        end
                        ost_pkg::OP_FIND: begin
                            if (in_range) begin
                                n_addr  = i_slot_index[IW-1:0];
                                n_state = S_SWEEP;
                            end else begin
                                n_strobe = 1'b1;
                                n_result = ost_pkg::NO_SLOT;
                                n_issue  = 1'b0;
                            end
                        end
                        ost_pkg::OP_COUNT_TYPE,
                        ost_pkg::OP_COUNT_OWN,
                        ost_pkg::OP_FIRST_FREE: begin
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_result = '0;
                            n_issue  = 1'b0;
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                // read side: one slot per cycle
                if (r_issue) begin
                    n_ev_v    = 1'b1;
                    n_ev_addr = r_addr;
                    n_ev_last = (r_addr == ost_pkg::LAST_SLOT);
                    if (r_addr == ost_pkg::LAST_SLOT) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end

                // evaluate side: data read in the previous cycle
                if (r_ev_v) begin
                    if (r_op == ost_pkg::OP_FREE) begin
                        if (cascade_hit) begin
                            mem_req.wr_type_en = 1'b1;
                            mem_req.wr_addr    = r_ev_addr;
                            mem_req.wr_type    = ost_pkg::TYPE_FREE;
                            n_marked[r_ev_addr] = 1'b1;
                            n_changed = 1'b1;
                        end
                        if (r_ev_last) begin
                            if (r_changed || cascade_hit) begin
                                // another pass: a new owner may have been freed
                                n_issue   = 1'b1;
                                n_addr    = '0;
                                n_changed = 1'b0;
                            end else begin
                                n_marked = '0;
                                n_strobe = 1'b1;
                                n_result = '0;
                                n_state  = S_IDLE;
                            end
                        end
                    end else if (r_op == ost_pkg::OP_FIND || r_op == ost_pkg::OP_FIRST_FREE) begin
                        if (match || r_ev_last) begin
                            n_strobe = 1'b1;
                            n_result = match ? 8'(r_ev_addr) : ost_pkg::NO_SLOT;
                            n_state  = S_IDLE;
                            n_issue  = 1'b0;
                            n_ev_v   = 1'b0;
                        end
                    end else begin
                        if (match) begin
                            n_count = r_count + 8'd1;
                        end
                        if (r_ev_last) begin
                            n_strobe = 1'b1;
                            n_result = match ? (r_count + 8'd1) : r_count;
                            n_state  = S_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
                n_issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_ev_v    <= 1'b0;
            r_marked  <= '0;
            r_changed <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_ev_v    <= n_ev_v;
            r_marked  <= n_marked;
            r_changed <= n_changed;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_typ     <= n_typ;
        r_own     <= n_own;
        r_addr    <= n_addr;
        r_ev_addr <= n_ev_addr;
        r_ev_last <= n_ev_last;
        r_count   <= n_count;
        r_result  <= n_result;
    end

endmodule

`default_nettype wire
